>>> hw/rtl/hpac_pkg.sv
// Package for the hash pre-aggregation cache: state encoding, controller
// command and status structs, register indexes, table size and field widths.
// No dependencies.
`default_nettype none
package hpac_pkg;

    // Slot count; a power of two so the home slot is the low hash bits.
    localparam int TABLE_SIZE = 32;

    localparam int KEY_W  = 32;
    localparam int SUM_W  = 32;
    localparam int HITS_W = 16;
    localparam int PART_W = 6;
    localparam int PC_W   = 7;
    localparam int THR_W  = 16;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] CFG_HASH_FACTOR     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PARTITION_COUNT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HIT_THRESHOLD   = 2'd2;

    localparam logic CMD_AGGREGATE = 1'b0;
    localparam logic CMD_FLUSH     = 1'b1;

    localparam logic [KEY_W-1:0]  RST_HASH_FACTOR = 32'd1;
    localparam logic [PC_W-1:0]   RST_PART_COUNT  = 7'd1;
    localparam logic [THR_W-1:0]  RST_HIT_THR     = 16'd10;
    localparam logic [PC_W-1:0]   MAX_PART_COUNT  = 7'd64;
    localparam logic [HITS_W-1:0] HITS_MAX        = 16'hFFFF;
    localparam logic [4:0]        DIV_LAST_STEP   = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DECIDE,
        ST_SCAN,
        ST_PROBE,
        ST_BYPASS
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic set_bypass;
        logic probe_init;
        logic scan_step;
        logic probe_step;
        logic emit_byp;
    } t_dp_cmd;

    typedef struct packed {
        logic is_flush;
        logic div_done;
        logic table_full;
        logic any_evict;
        logic bypass;
        logic scan_adv;
        logic scan_at_end;
        logic probe_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> hw/rtl/hpac_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Payload widths follow hpac_pkg.
`default_nettype none
interface hpac_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] group_key;
    logic [31:0] value;
    modport source (output valid, command, group_key, value, input ready);
    modport sink   (input valid, command, group_key, value, output ready);
endinterface

interface hpac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_key;
    logic [31:0] out_sum;
    logic [5:0]  out_partition;
    logic        out_last;
    modport source (output valid, out_key, out_sum, out_partition, out_last, input ready);
    modport sink   (input valid, out_key, out_sum, out_partition, out_last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/hpac_rem.sv
// Bit-serial remainder unit: one dividend bit per step, restoring subtract.
// Used by hpac_datapath for the partition tag.
`default_nettype none
module hpac_rem #(
    parameter int W = 7
) (
    input  wire logic         i_clk,
    input  wire logic         i_clr,
    input  wire logic         i_step,
    input  wire logic         i_bit,
    input  wire logic [W-1:0] i_div,
    output logic      [W-1:0] o_rem
);
    logic [W-1:0] r_rem;
    logic [W-1:0] n_rem;
    logic [W:0]   w_t;

    always_comb begin
        w_t   = {r_rem, i_bit};
        n_rem = r_rem;
        if (i_clr) begin
            n_rem = '0;
        end else if (i_step) begin
            if (w_t >= {1'b0, i_div}) begin
                n_rem = W'(w_t - {1'b0, i_div});
            end else begin
                n_rem = W'(w_t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

    assign o_rem = r_rem;
endmodule
`default_nettype wire

>>> hw/rtl/hpac_ctrl.sv
// Controller state machine: sequences hash, remainder, eviction or flush
// scan, probe and bypass emission. Uses hpac_pkg command/status structs.
`default_nettype none
module hpac_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire hpac_pkg::t_dp_sts i_sts,
    output hpac_pkg::t_dp_cmd     o_cmd
);
    import hpac_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_sts.is_flush) begin
                    n_state = ST_SCAN;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.probe_init = 1'b1;
                if (!i_sts.bypass && i_sts.table_full) begin
                    if (i_sts.any_evict) begin
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.set_bypass = 1'b1;
                        n_state          = ST_BYPASS;
                    end
                end else if (i_sts.bypass) begin
                    n_state = ST_BYPASS;
                end else begin
                    n_state = ST_PROBE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_adv && i_sts.scan_at_end) begin
                    n_state = i_sts.is_flush ? ST_IDLE : ST_PROBE;
                end
            end
            ST_PROBE: begin
                o_cmd.probe_step = 1'b1;
                if (i_sts.probe_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BYPASS: begin
                o_cmd.emit_byp = 1'b1;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> hw/rtl/hpac_datapath.sv
// Datapath: config registers, hash multiplier, partition remainder unit, slot
// table, scan and probe pointers, and the result output register.
// Depends on hpac_pkg, hpac_if and hpac_rem.
`default_nettype none
module hpac_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [hpac_pkg::CIDX_W-1:0] i_cfg_idx,
    input  wire logic [hpac_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                      i_command,
    input  wire logic [31:0]               i_group_key,
    input  wire logic [31:0]               i_value,
    input  wire hpac_pkg::t_dp_cmd         i_cmd,
    output hpac_pkg::t_dp_sts              o_sts,
    hpac_out_if.source                     o_out
);
    import hpac_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);

    logic [KEY_W-1:0]  r_hash_factor;
    logic [PC_W-1:0]   r_part_cnt;
    logic [THR_W-1:0]  r_hit_thr;

    logic              r_flush;
    logic [KEY_W-1:0]  r_key;
    logic [SUM_W-1:0]  r_val;
    logic [31:0]       r_shift;
    logic [4:0]        r_cnt;
    logic [IW-1:0]     r_home;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_pos;
    logic [CW-1:0]     r_count;
    logic              r_bypass;

    logic [KEY_W-1:0]  r_slot_key  [TABLE_SIZE];
    logic [SUM_W-1:0]  r_slot_sum  [TABLE_SIZE];
    logic [PART_W-1:0] r_slot_part [TABLE_SIZE];
    logic [HITS_W-1:0] r_slot_hits [TABLE_SIZE];

    logic              r_ovalid;
    logic [KEY_W-1:0]  r_okey;
    logic [SUM_W-1:0]  r_osum;
    logic [PART_W-1:0] r_opart;
    logic              r_olast;

    logic [KEY_W-1:0]  w_hash;
    logic [PC_W-1:0]   w_pc_div;
    logic [PC_W-1:0]   w_rem_pc;
    logic [TABLE_SIZE-1:0] w_qual;
    logic [TABLE_SIZE-1:0] w_above;
    logic              w_cur_qual;
    logic              w_later;
    logic              w_out_free;
    logic              w_scan_emit;
    logic              w_p_empty;
    logic              w_p_match;
    logic              w_insert;
    logic              w_update;
    logic              w_byp_emit;

    // Partition count outside 1..64 is clamped.
    always_comb begin
        if (r_part_cnt == '0) begin
            w_pc_div = PC_W'(1);
        end else if (r_part_cnt > MAX_PART_COUNT) begin
            w_pc_div = MAX_PART_COUNT;
        end else begin
            w_pc_div = r_part_cnt;
        end
    end

    assign w_hash = r_key * r_hash_factor;

    hpac_rem #(.W(PC_W)) u_rem_pc (
        .i_clk  (i_clk),
        .i_clr  (i_cmd.mul),
        .i_step (i_cmd.div_step),
        .i_bit  (r_shift[31]),
        .i_div  (w_pc_div),
        .o_rem  (w_rem_pc)
    );

    always_comb begin
        for (int j = 0; j < TABLE_SIZE; j++) begin
            w_qual[j]  = (r_slot_hits[j] != '0) && (r_flush || (r_slot_hits[j] < r_hit_thr));
            w_above[j] = (IW'(j) > r_idx);
        end
    end

    assign w_cur_qual  = w_qual[r_idx];
    assign w_later     = |(w_qual & w_above);
    assign w_out_free  = !r_ovalid || o_out.ready;
    assign w_scan_emit = i_cmd.scan_step && w_cur_qual && w_out_free;
    assign w_byp_emit  = i_cmd.emit_byp && w_out_free;

    assign w_p_empty = (r_slot_hits[r_pos] == '0);
    assign w_p_match = (r_slot_key[r_pos] == r_key);
    assign w_insert  = i_cmd.probe_step && w_p_empty;
    assign w_update  = i_cmd.probe_step && !w_p_empty && w_p_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_factor <= RST_HASH_FACTOR;
            r_part_cnt    <= RST_PART_COUNT;
            r_hit_thr     <= RST_HIT_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HASH_FACTOR:     r_hash_factor <= i_cfg_data;
                CFG_PARTITION_COUNT: r_part_cnt    <= i_cfg_data[PC_W-1:0];
                CFG_HIT_THRESHOLD:   r_hit_thr     <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Transaction fields and hash shift register; home slot is the low hash bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_flush <= (i_command == CMD_FLUSH);
            r_key   <= i_group_key;
            r_val   <= i_value;
        end
        if (i_cmd.mul) begin
            r_shift <= w_hash;
            r_home  <= w_hash[IW-1:0];
            r_cnt   <= '0;
        end else if (i_cmd.div_step) begin
            r_shift <= {r_shift[30:0], 1'b0};
            r_cnt   <= r_cnt + 5'd1;
        end
        if (i_cmd.probe_init) begin
            r_pos <= r_home;
        end else if (i_cmd.probe_step && !w_p_empty && !w_p_match) begin
            r_pos <= (r_pos == IW'(TABLE_SIZE - 1)) ? '0 : r_pos + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_count  <= '0;
            r_bypass <= 1'b0;
            for (int j = 0; j < TABLE_SIZE; j++) begin
                r_slot_hits[j] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step && (!w_cur_qual || w_out_free)) begin
                r_idx <= (r_idx == IW'(TABLE_SIZE - 1)) ? '0 : r_idx + IW'(1);
            end
            if (i_cmd.set_bypass) begin
                r_bypass <= 1'b1;
            end
            if (w_scan_emit) begin
                r_slot_hits[r_idx] <= '0;
                r_count            <= r_count - CW'(1);
            end
            if (w_insert) begin
                r_slot_hits[r_pos] <= HITS_W'(1);
                r_count            <= r_count + CW'(1);
            end else if (w_update && (r_slot_hits[r_pos] != HITS_MAX)) begin
                r_slot_hits[r_pos] <= r_slot_hits[r_pos] + HITS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_slot_key[r_pos]  <= r_key;
            r_slot_sum[r_pos]  <= r_val;
            r_slot_part[r_pos] <= w_rem_pc[PART_W-1:0];
        end else if (w_update) begin
            r_slot_sum[r_pos]  <= r_slot_sum[r_pos] + r_val;
        end
    end

    // Result register: load on emit, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_scan_emit || w_byp_emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_emit) begin
            r_okey  <= r_slot_key[r_idx];
            r_osum  <= r_slot_sum[r_idx];
            r_opart <= r_slot_part[r_idx];
            r_olast <= !w_later;
        end else if (w_byp_emit) begin
            r_okey  <= r_key;
            r_osum  <= r_val;
            r_opart <= w_rem_pc[PART_W-1:0];
            r_olast <= 1'b1;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.out_key       = r_okey;
    assign o_out.out_sum       = r_osum;
    assign o_out.out_partition = r_opart;
    assign o_out.out_last      = r_olast;

    assign o_sts.is_flush    = r_flush;
    assign o_sts.div_done    = (r_cnt == DIV_LAST_STEP);
    assign o_sts.table_full  = (r_count == CW'(TABLE_SIZE));
    assign o_sts.any_evict   = |w_qual;
    assign o_sts.bypass      = r_bypass;
    assign o_sts.scan_adv    = !w_cur_qual || w_out_free;
    assign o_sts.scan_at_end = (r_idx == IW'(TABLE_SIZE - 1));
    assign o_sts.probe_done  = w_p_empty || w_p_match;
    assign o_sts.out_free    = w_out_free;
endmodule
`default_nettype wire

>>> hw/rtl/hash_preaggregation_cache_core.sv
// Hash pre-aggregation cache, top level. Aggregate: accept, multiply, 32 serial
// partition-remainder steps, decide, then an eviction scan if the table is full,
// then the probe. Bypass (entered when nothing can be evicted): accept, multiply,
// remainder, decide, emit. Flush: accept, scan. Output stalls hold scan and emit.
// One transaction at a time; the result register lets the next one start while
// a result waits. Synchronous active-low reset empties the table; no clearing pass.
`default_nettype none
module hash_preaggregation_cache_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hpac_pkg::CIDX_W-1:0] i_cfg_idx,
    input  wire logic [hpac_pkg::CFG_W-1:0]  i_cfg_data,
    hpac_in_if.sink                          i_in,
    hpac_out_if.source                       o_out
);
    import hpac_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    hpac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hpac_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_in.command),
        .i_group_key (i_in.group_key),
        .i_value     (i_in.value),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out)
    );

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load == (i_in.valid && w_in_ready))
        else $error("load without input transaction");

    a_bypass_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.set_bypass |=> w_sts.bypass)
        else $error("bypass not entered");

    a_bypass_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.bypass |=> w_sts.bypass)
        else $error("bypass cleared outside reset");

    a_probe_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.probe_step |-> !w_sts.table_full)
        else $error("probe on a full table");
endmodule
`default_nettype wire

>>> bench/hash_preaggregation_cache_core_tb.sv
// Testbench for hash_preaggregation_cache_core: random and directed aggregate
// and flush transactions, checked against an in-bench model of the group table.
// Depends on hpac_pkg and the hpac_in_if / hpac_out_if interfaces.
`default_nettype none
module hash_preaggregation_cache_core_tb;
    import hpac_pkg::*;

    localparam int NSLOT       = TABLE_SIZE;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 150;

    typedef struct packed {
        logic        cmd;
        logic [31:0] key;
        logic [31:0] val;
    } t_item;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] sum;
        logic [5:0]  part;
        logic        last;
    } t_group_out;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    hpac_in_if  in_ch ();
    hpac_out_if out_ch ();

    hash_preaggregation_cache_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // model state
    logic [31:0] m_factor;
    logic [6:0]  m_pcount;
    logic [15:0] m_thresh;
    logic [31:0] m_key  [NSLOT];
    logic [31:0] m_sum  [NSLOT];
    logic [15:0] m_hits [NSLOT];
    logic [5:0]  m_part [NSLOT];
    int          m_occupied;
    bit          m_bypass;

    t_item      pending_items[$];
    t_group_out expected_groups[$];
    logic [31:0] key_pool[64];

    int  errors = 0;
    int  cycles = 0;
    int  n_results = 0;
    int  n_flushes = 0;
    int  n_aggregates = 0;
    bit  hold_req = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout at cycle %0d", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [5:0] part_of(logic [31:0] h);
        logic [6:0] pc;
        pc = m_pcount;
        if (pc == 0) pc = 1;
        if (pc > MAX_PART_COUNT) pc = MAX_PART_COUNT;
        return 6'(h % pc);
    endfunction

    function automatic void push_group(logic [31:0] k, logic [31:0] s, logic [5:0] p);
        t_group_out g;
        g.key = k; g.sum = s; g.part = p; g.last = 1'b0;
        expected_groups.insert(expected_groups.size(), g);
    endfunction

    function automatic void free_slot(int s);
        push_group(m_key[s], m_sum[s], m_part[s]);
        m_hits[s] = 0;
        m_occupied--;
    endfunction

    // Work out the groups one transaction emits and update the table.
    function automatic void predict_groups(t_item it);
        int n, pos, k;
        logic [31:0] h;
        logic [5:0]  p;
        n = 0;
        if (it.cmd == CMD_FLUSH) begin
            for (int s = 0; s < NSLOT; s++)
                if (m_hits[s] != 0) begin free_slot(s); n++; end
        end else begin
            h = it.key * m_factor;
            p = part_of(h);
            if (!m_bypass && m_occupied >= NSLOT) begin
                for (int s = 0; s < NSLOT; s++)
                    if (m_hits[s] != 0 && m_hits[s] < m_thresh) begin free_slot(s); n++; end
                if (n == 0) m_bypass = 1;
            end
            if (m_bypass) begin
                push_group(it.key, it.val, p);
                n++;
            end else begin
                pos = h[4:0];
                for (k = 0; k < NSLOT; k++) begin
                    if (m_hits[pos] == 0 || m_key[pos] == it.key) break;
                    pos = (pos + 1) % NSLOT;
                end
                if (m_hits[pos] == 0) begin
                    m_key[pos] = it.key; m_sum[pos] = it.val;
                    m_part[pos] = p; m_hits[pos] = 1;
                    m_occupied++;
                end else begin
                    m_sum[pos] = m_sum[pos] + it.val;
                    if (m_hits[pos] != HITS_MAX) m_hits[pos]++;
                end
            end
        end
        if (n > 0) expected_groups[$].last = 1'b1;
    endfunction

    // Sender: bursts of random length with random gaps.
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_item nxt;
        logic  v;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.command <= CMD_AGGREGATE;
            in_ch.group_key <= '0;
            in_ch.value <= '0;
        end else begin
            v = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                nxt.cmd = in_ch.command; nxt.key = in_ch.group_key; nxt.val = in_ch.value;
                if (nxt.cmd == CMD_FLUSH) n_flushes++; else n_aggregates++;
                predict_groups(nxt);
                v = 1'b0;
            end
            if (!v) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    in_ch.command <= nxt.cmd;
                    in_ch.group_key <= nxt.key;
                    in_ch.value <= nxt.val;
                    v = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                                : $urandom_range(0, 5);
                    end
                end
            end
            in_ch.valid <= v;
        end
    end

    // Receiver: stall pattern that rotates through four modes, plus long holds.
    int stall_left = 0;
    always @(posedge i_clk) begin
        logic r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_req = 0;
                stall_left = 3000;
            end
            if (stall_left > 0) begin
                stall_left--;
                r = 1'b0;
            end else begin
                case ((cycles / 256) % 4)
                    0: r = 1'b1;
                    1: r = ($urandom_range(0, 1) == 1);
                    2: r = ($urandom_range(0, 6) != 0);
                    default: r = (cycles % 3 == 0);
                endcase
            end
            out_ch.ready <= r;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_group_out g;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (expected_groups.size() == 0) begin
                errors++;
                $display("%0t: unexpected result key=%h sum=%h part=%0d last=%b", $time,
                         out_ch.out_key, out_ch.out_sum, out_ch.out_partition, out_ch.out_last);
            end else begin
                g = expected_groups.pop_front();
                if (out_ch.out_key !== g.key) begin
                    errors++;
                    $display("%0t: out_key expected %h actual %h", $time, g.key, out_ch.out_key);
                end
                if (out_ch.out_sum !== g.sum) begin
                    errors++;
                    $display("%0t: out_sum expected %h actual %h", $time, g.sum, out_ch.out_sum);
                end
                if (out_ch.out_partition !== g.part) begin
                    errors++;
                    $display("%0t: out_partition expected %0d actual %0d", $time, g.part,
                             out_ch.out_partition);
                end
                if (out_ch.out_last !== g.last) begin
                    errors++;
                    $display("%0t: out_last expected %b actual %b", $time, g.last,
                             out_ch.out_last);
                end
            end
        end
    end

    task automatic add_item(logic cmd, logic [31:0] k, logic [31:0] v);
        t_item it;
        it.cmd = cmd; it.key = k; it.val = v;
        pending_items.insert(pending_items.size(), it);
    endtask

    // Mostly pooled keys so groups collect hits; some fully random keys.
    task automatic add_random(int count, int pool_n, int flush_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < flush_pct)
                add_item(CMD_FLUSH, $urandom, $urandom);
            else if ($urandom_range(0, 9) == 0)
                add_item(CMD_AGGREGATE, $urandom, $urandom);
            else
                add_item(CMD_AGGREGATE, key_pool[$urandom_range(0, pool_n - 1)], $urandom);
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_groups.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [31:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_HASH_FACTOR:     m_factor = d;
            CFG_PARTITION_COUNT: m_pcount = d[6:0];
            default:             m_thresh = d[15:0];
        endcase
    endtask

    task automatic set_config(logic [31:0] f, logic [31:0] pc, logic [31:0] thr);
        cfg_write(CFG_HASH_FACTOR, f);
        cfg_write(CFG_PARTITION_COUNT, pc);
        cfg_write(CFG_HIT_THRESHOLD, thr);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        m_factor = RST_HASH_FACTOR;
        m_pcount = RST_PART_COUNT;
        m_thresh = RST_HIT_THR;
        for (int s = 0; s < NSLOT; s++) begin
            m_key[s] = '0; m_sum[s] = '0; m_hits[s] = '0; m_part[s] = '0;
        end
        m_occupied = 0;
        m_bypass = 0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, wrapping sums, probe collisions, flushes.
        add_item(CMD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(CMD_AGGREGATE, 32'h0, 32'h0);
        add_item(CMD_AGGREGATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(CMD_AGGREGATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(CMD_AGGREGATE, 32'd5, 32'h8000_0000);
        add_item(CMD_AGGREGATE, 32'd37, 32'd1);
        add_item(CMD_AGGREGATE, 32'd69, 32'd2);
        add_item(CMD_AGGREGATE, 32'd5, 32'h8000_0000);
        add_item(CMD_AGGREGATE, 32'd31, 32'h5555_5555);
        add_item(CMD_AGGREGATE, 32'd63, 32'hAAAA_AAAA);
        add_item(CMD_AGGREGATE, 32'h8000_0000, 32'h1);
        add_item(CMD_FLUSH, 32'h0, 32'h0);
        add_item(CMD_FLUSH, 32'h0, 32'h0);
        // fill the table, then overflow it so low-hit entries get evicted
        for (int i = 0; i < 33; i++) add_item(CMD_AGGREGATE, 32'h100 + i, i);
        add_item(CMD_FLUSH, 32'h0, 32'h0);
        drain();

        // Hold the result side off while flushes back up the block.
        set_config($urandom | 32'h1, 64, 3);
        for (int i = 0; i < 32; i++) add_item(CMD_AGGREGATE, key_pool[i], $urandom);
        add_item(CMD_FLUSH, 32'h0, 32'h0);
        for (int i = 0; i < 8; i++) add_item(CMD_AGGREGATE, key_pool[i], $urandom);
        add_item(CMD_FLUSH, 32'h0, 32'h0);
        hold_req = 1;
        add_random(40, 48, 5);
        drain();

        set_config(32'hFFFF_FFFF, 0, 16'hFFFF);
        add_random(40, 56, 4);
        drain();

        set_config(32'h0, 100, 2);
        add_random(30, 40, 6);
        drain();

        set_config($urandom | 32'h1, $urandom_range(1, 64), 4);
        add_random(40, 44, 5);
        drain();

        // Threshold zero: a full table turns bypass on for the rest of the run.
        set_config($urandom | 32'h1, 64, 0);
        add_item(CMD_FLUSH, 32'h0, 32'h0);
        for (int i = 0; i < 32; i++) add_item(CMD_AGGREGATE, key_pool[i], $urandom);
        add_random(20, 64, 0);
        add_item(CMD_FLUSH, 32'h0, 32'h0);
        add_item(CMD_FLUSH, 32'h0, 32'h0);
        add_random(10, 64, 10);
        drain();

        $display("Covered %0d aggregate and %0d flush transactions, %0d results checked,",
                 n_aggregates, n_flushes, n_results);
        $display("over six register settings ending in the sticky bypass mode.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> hash_preaggregation_cache_core.f
hw/rtl/hpac_pkg.sv
hw/rtl/hpac_if.sv
hw/rtl/hpac_rem.sv
hw/rtl/hpac_ctrl.sv
hw/rtl/hpac_datapath.sv
hw/rtl/hash_preaggregation_cache_core.sv
bench/hash_preaggregation_cache_core_tb.sv
